### sv/lztd_pkg.sv
// lztd_pkg: shared types and constants of the lz78 token decoder
// no dependencies; used by every module of the block but lztd_ram

package lztd_pkg;

	localparam int IDX_W = 16;
	localparam int SYM_W = 8;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_BAD_INDEX = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_HALTED    = 3'd4
	} status_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_flags_t;

endpackage

### sv/lztd_ram.sv
// lztd_ram: generic one-write one-read memory with registered read data
// no dependencies

module lztd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/lztd_fifo.sv
// lztd_fifo: two-entry command queue between front and back
// depends on lztd_pkg

module lztd_fifo #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 pop,
	output logic [WIDTH-1:0]     rdata,
	output lztd_pkg::fifo_flags_t flags
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign rdata       = slot_q[rd_ptr_q];
	assign flags.full  = (cnt_q == 2'd2);
	assign flags.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!flags.full || pop)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !flags.empty) else $error("pop from empty queue");

endmodule

### sv/lztd_front.sv
// lztd_front: accepts tokens, checks them against the dictionary and appends entries
// depends on lztd_pkg and lztd_ram

module lztd_front #(
	parameter int DICT_ENTRIES = 4096,
	parameter int MAX_STRING   = 64,
	localparam int CW = $clog2(DICT_ENTRIES + 1),
	localparam int AW = $clog2(DICT_ENTRIES),
	localparam int LW = $clog2(MAX_STRING + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lztd_pkg::IDX_W-1:0]  dict_index,
	input  logic [lztd_pkg::SYM_W-1:0]  symbol,
	input  logic                        token_valid,
	output logic                        token_stall,
	input  lztd_pkg::fifo_flags_t       flags,
	output logic                        push,
	output lztd_pkg::status_t           push_status,
	output logic [CW-1:0]               push_idx,
	output logic [lztd_pkg::SYM_W-1:0]  push_sym,
	output logic [LW-1:0]               push_len,
	output logic                        dict_we,
	output logic [AW-1:0]               dict_waddr
);

	typedef enum logic {F_IDLE, F_LOOK} fstate_t;

	fstate_t                     state_q;
	logic [lztd_pkg::IDX_W-1:0]  idx_s1;
	logic [lztd_pkg::SYM_W-1:0]  sym_s1;
	logic [CW-1:0]               count_q;
	logic                        halted_q;
	logic [LW-1:0]               len_rdata;
	logic [LW:0]                 len_calc;
	logic [lztd_pkg::IDX_W-1:0]  idx_m1;
	lztd_pkg::status_t           cls;

	assign token_stall = !((state_q == F_IDLE) && !flags.full);
	assign idx_m1      = dict_index - lztd_pkg::IDX_W'(1);

	// length of each entry, read while the token is taken
	lztd_ram #(.WIDTH(LW), .DEPTH(DICT_ENTRIES)) u_len_ram (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (len_calc[LW-1:0]),
		.raddr (idx_m1[AW-1:0]),
		.rdata (len_rdata)
	);

	always_comb begin
		len_calc = (idx_s1 == '0) ? (LW+1)'(1) : ({1'b0, len_rdata} + (LW+1)'(1));
		if (halted_q) begin
			cls = lztd_pkg::ST_HALTED;
		end else if (count_q >= CW'(DICT_ENTRIES)) begin
			cls = lztd_pkg::ST_FULL;
		end else if (17'(idx_s1) > 17'(count_q)) begin
			cls = lztd_pkg::ST_BAD_INDEX;
		end else if (len_calc > (LW+1)'(MAX_STRING)) begin
			cls = lztd_pkg::ST_TOO_LONG;
		end else begin
			cls = lztd_pkg::ST_OK;
		end
	end

	assign push        = (state_q == F_LOOK);
	assign push_status = cls;
	assign push_idx    = idx_s1[CW-1:0];
	assign push_sym    = sym_s1;
	assign push_len    = len_calc[LW-1:0];
	assign dict_we     = (state_q == F_LOOK) && (cls == lztd_pkg::ST_OK);
	assign dict_waddr  = count_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			count_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (token_valid && !token_stall) begin
						state_q <= F_LOOK;
					end
				end
				F_LOOK: begin
					state_q <= F_IDLE;
					if (cls == lztd_pkg::ST_OK) begin
						count_q <= count_q + CW'(1);
					end else begin
						halted_q <= 1'b1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (token_valid && !token_stall) begin
			idx_s1 <= dict_index;
			sym_s1 <= symbol;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halted flag dropped");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		dict_we |-> (count_q < CW'(DICT_ENTRIES))) else $error("append past dictionary end");

endmodule

### sv/lztd_back.sv
// lztd_back: walks the parent chain of each good token and emits its bytes
// depends on lztd_pkg and lztd_ram

module lztd_back #(
	parameter int DICT_ENTRIES = 4096,
	parameter int MAX_STRING   = 64,
	localparam int CW = $clog2(DICT_ENTRIES + 1),
	localparam int AW = $clog2(DICT_ENTRIES),
	localparam int LW = $clog2(MAX_STRING + 1),
	localparam int BW = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lztd_pkg::fifo_flags_t       flags,
	output logic                        pop,
	input  lztd_pkg::status_t           cmd_status,
	input  logic [CW-1:0]               cmd_idx,
	input  logic [lztd_pkg::SYM_W-1:0]  cmd_sym,
	input  logic [LW-1:0]               cmd_len,
	output logic [AW-1:0]               dict_raddr,
	input  logic [CW-1:0]               rd_parent,
	input  logic [lztd_pkg::SYM_W-1:0]  rd_sym,
	output logic [lztd_pkg::SYM_W-1:0]  out_byte,
	output logic                        last_of_token,
	output logic [2:0]                  status,
	output logic                        result_valid,
	input  logic                        result_stall
);

	typedef enum logic [2:0] {B_IDLE, B_START, B_WALK, B_PRIME, B_EMIT} bstate_t;

	bstate_t                     state_q;
	logic                        valid_q;
	logic [lztd_pkg::SYM_W-1:0]  byte_q;
	logic                        last_q;
	lztd_pkg::status_t           status_q;
	logic [CW-1:0]               p_q;
	logic [lztd_pkg::SYM_W-1:0]  sym_q;
	logic [BW-1:0]               lm1_q;
	logic [BW-1:0]               k_q;
	logic                        out_free;
	logic [LW-1:0]               cmd_lm1;
	logic [CW-1:0]               link_m1;
	logic                        buf_we;
	logic [BW-1:0]               buf_waddr;
	logic [lztd_pkg::SYM_W-1:0]  buf_wdata;
	logic [BW-1:0]               buf_raddr;
	logic [lztd_pkg::SYM_W-1:0]  buf_rdata;

	assign result_valid  = valid_q;
	assign out_byte      = byte_q;
	assign last_of_token = last_q;
	assign status        = status_q;

	assign out_free = !valid_q || !result_stall;
	assign pop      = (state_q == B_IDLE) && !flags.empty &&
	                  ((cmd_status == lztd_pkg::ST_OK) || out_free);
	assign cmd_lm1  = cmd_len - LW'(1);

	// next link comes straight from the entry just read
	assign link_m1    = ((state_q == B_WALK) ? rd_parent : p_q) - CW'(1);
	assign dict_raddr = link_m1[AW-1:0];

	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = lm1_q;
		buf_wdata = sym_q;
		if (state_q == B_START) begin
			buf_we = 1'b1;
		end else if (state_q == B_WALK) begin
			buf_we    = 1'b1;
			buf_waddr = k_q - BW'(1);
			buf_wdata = (p_q == '0) ? '0 : rd_sym;
		end
		buf_raddr = ((state_q == B_EMIT) && out_free) ? (k_q + BW'(1)) : k_q;
	end

	lztd_ram #(.WIDTH(lztd_pkg::SYM_W), .DEPTH(MAX_STRING)) u_rev_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && !result_stall) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (cmd_status != lztd_pkg::ST_OK) begin
							valid_q  <= 1'b1;
							byte_q   <= '0;
							last_q   <= 1'b1;
							status_q <= cmd_status;
						end else begin
							p_q     <= cmd_idx;
							sym_q   <= cmd_sym;
							lm1_q   <= cmd_lm1[BW-1:0];
							k_q     <= cmd_lm1[BW-1:0];
							state_q <= B_START;
						end
					end
				end
				B_START: begin
					state_q <= (lm1_q == '0) ? B_PRIME : B_WALK;
				end
				B_WALK: begin
					k_q <= k_q - BW'(1);
					p_q <= (p_q == '0) ? '0 : rd_parent;
					if (k_q == BW'(1)) begin
						state_q <= B_PRIME;
					end
				end
				B_PRIME: begin
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (out_free) begin
						valid_q  <= 1'b1;
						byte_q   <= buf_rdata;
						last_q   <= (k_q == lm1_q);
						status_q <= lztd_pkg::ST_OK;
						k_q      <= k_q + BW'(1);
						if (k_q == lm1_q) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q != lztd_pkg::ST_OK) |-> (last_q && byte_q == '0))
		else $error("error result carries data");
	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WALK) |-> (k_q != '0)) else $error("walk ran past string start");

endmodule

### sv/lz78_token_decoder_top.sv
// lz78_token_decoder_top: lz78 token decoder, front checker, command queue and back emitter
// depends on lztd_pkg, lztd_ram, lztd_fifo, lztd_front, lztd_back
//
// token channel: dict_index and symbol under token_valid / token_stall. index 0 means
// no prefix, index k means dictionary entry k-1.
// result channel: out_byte, last_of_token and status under result_valid / result_stall.
// a good token gives one result per byte of its string, last_of_token on the final one.
// a failing token gives a single result with out_byte 0 and an error status; from then
// on every token gets a single halted result until reset.
// the front takes a token in F_IDLE and pushes its check in F_LOOK, after the length lookup,
// so it takes no new token before that push; the back takes the request, stores the
// symbol, walks the parent links through the dictionary ram, makes one priming read of
// the string buffer, then gives one byte per cycle while the receiver does not stall, and
// takes no new request until the last byte. an error result comes straight from the request.
// a two-entry queue lets the front check the next tokens while the back is busy.
// reset clears the entry count, the halted flag, the queue and the output valid flag;
// the dictionary rams hold nothing meaningful until entries are appended.
// when the receiver stalls, the result register holds and the back waits; the front
// keeps taking tokens until the queue fills.

module lz78_token_decoder_top #(
	parameter int DICT_ENTRIES = 4096,
	parameter int MAX_STRING   = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lztd_pkg::IDX_W-1:0]  dict_index,
	input  logic [lztd_pkg::SYM_W-1:0]  symbol,
	input  logic                        token_valid,
	output logic                        token_stall,
	output logic [lztd_pkg::SYM_W-1:0]  out_byte,
	output logic                        last_of_token,
	output logic [2:0]                  status,
	output logic                        result_valid,
	input  logic                        result_stall
);

	localparam int CW = $clog2(DICT_ENTRIES + 1);
	localparam int AW = $clog2(DICT_ENTRIES);
	localparam int LW = $clog2(MAX_STRING + 1);
	localparam int QW = 3 + CW + lztd_pkg::SYM_W + LW;

	lztd_pkg::fifo_flags_t       flags;
	logic                        push;
	logic                        pop;
	lztd_pkg::status_t           push_status;
	logic [CW-1:0]               push_idx;
	logic [lztd_pkg::SYM_W-1:0]  push_sym;
	logic [LW-1:0]               push_len;
	logic [QW-1:0]               q_rdata;
	lztd_pkg::status_t           cmd_status;
	logic [CW-1:0]               cmd_idx;
	logic [lztd_pkg::SYM_W-1:0]  cmd_sym;
	logic [LW-1:0]               cmd_len;
	logic                        dict_we;
	logic [AW-1:0]               dict_waddr;
	logic [AW-1:0]               dict_raddr;
	logic [CW-1:0]               rd_parent;
	logic [lztd_pkg::SYM_W-1:0]  rd_sym;

	lztd_front #(.DICT_ENTRIES(DICT_ENTRIES), .MAX_STRING(MAX_STRING)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.dict_index  (dict_index),
		.symbol      (symbol),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.flags       (flags),
		.push        (push),
		.push_status (push_status),
		.push_idx    (push_idx),
		.push_sym    (push_sym),
		.push_len    (push_len),
		.dict_we     (dict_we),
		.dict_waddr  (dict_waddr)
	);

	// parent link and last byte of each entry
	lztd_ram #(.WIDTH(CW + lztd_pkg::SYM_W), .DEPTH(DICT_ENTRIES)) u_dict_ram (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata ({push_idx, push_sym}),
		.raddr (dict_raddr),
		.rdata ({rd_parent, rd_sym})
	);

	lztd_fifo #(.WIDTH(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_status, push_idx, push_sym, push_len}),
		.pop    (pop),
		.rdata  (q_rdata),
		.flags  (flags)
	);

	assign cmd_status = lztd_pkg::status_t'(q_rdata[QW-1 -: 3]);
	assign cmd_idx    = q_rdata[LW + lztd_pkg::SYM_W +: CW];
	assign cmd_sym    = q_rdata[LW +: lztd_pkg::SYM_W];
	assign cmd_len    = q_rdata[LW-1:0];

	lztd_back #(.DICT_ENTRIES(DICT_ENTRIES), .MAX_STRING(MAX_STRING)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.flags         (flags),
		.pop           (pop),
		.cmd_status    (cmd_status),
		.cmd_idx       (cmd_idx),
		.cmd_sym       (cmd_sym),
		.cmd_len       (cmd_len),
		.dict_raddr    (dict_raddr),
		.rd_parent     (rd_parent),
		.rd_sym        (rd_sym),
		.out_byte      (out_byte),
		.last_of_token (last_of_token),
		.status        (status),
		.result_valid  (result_valid),
		.result_stall  (result_stall)
	);

endmodule
